// ----- hw/rtl/kvs_pkg.sv -----
// Shared constants, codes and types of the keyframe vector sampler.
`default_nettype none

package kvs_pkg;

  localparam int MAX_KEYS = 64;
  localparam int KEY_AW   = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int FRAC_W   = 17;                  // Q0.16 fraction plus the t == t1 bit
  localparam int STEP_W   = $clog2(FRAC_W + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_SAMPLED = 2'd0,
    ST_DONE    = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    logic              en;
    logic [KEY_AW-1:0] addr;
    logic [31:0]       key_time;
    logic [31:0]       key_x;
    logic [31:0]       key_y;
    logic [31:0]       key_z;
  } kvs_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/kvs_if.sv -----
// Request and response channel interfaces of the keyframe vector sampler.
`default_nettype none

interface kvs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] key_time;
  logic [31:0] key_x;
  logic [31:0] key_y;
  logic [31:0] key_z;
  logic [31:0] sample_time;

  modport source (output valid, opcode, key_time, key_x, key_y, key_z, sample_time,
                  input ready);
  modport sink   (input valid, opcode, key_time, key_x, key_y, key_z, sample_time,
                  output ready);
endinterface

interface kvs_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [1:0]  status;

  modport source (output valid, out_x, out_y, out_z, status, input ready);
  modport sink   (input valid, out_x, out_y, out_z, status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/kvs_store.sv -----
// Keyframe store: time and xyz memories, one write and one registered read port.
`default_nettype none

module kvs_store
  import kvs_pkg::*;
(
  input  wire logic              clk,
  input  wire kvs_wr_t           wr,
  input  wire logic [KEY_AW-1:0] rd_addr,
  output logic [31:0]            rd_time,
  output logic [31:0]            rd_x,
  output logic [31:0]            rd_y,
  output logic [31:0]            rd_z
);

  logic [31:0] time_mem [MAX_KEYS];
  logic [95:0] xyz_mem  [MAX_KEYS];
  logic [95:0] xyz_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      time_mem[wr.addr] <= wr.key_time;
      xyz_mem[wr.addr]  <= {wr.key_x, wr.key_y, wr.key_z};
    end
    rd_time <= time_mem[rd_addr];
    xyz_q   <= xyz_mem[rd_addr];
  end

  assign rd_x = xyz_q[95:64];
  assign rd_y = xyz_q[63:32];
  assign rd_z = xyz_q[31:0];

endmodule

`default_nettype wire

// ----- hw/rtl/kvs_div.sv -----
// Serial restoring divider for the Q0.16 segment fraction, one quotient bit a cycle.
`default_nettype none

module kvs_div
  import kvs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [31:0]       num,   // t - t0, never above den
  input  wire logic [31:0]       den,   // t1 - t0, nonzero
  output logic                   done,
  output logic [FRAC_W-1:0]      quot
);

  logic [32:0]       rem;
  logic [32:0]       rem_sub;
  logic [32:0]       rem_next;
  logic              ge;
  logic [STEP_W-1:0] steps;
  logic              running;

  // Remainder stays below den, so a 33-bit working register is enough.
  always_comb begin
    rem_sub  = rem - {1'b0, den};
    ge       = rem >= {1'b0, den};
    rem_next = ge ? rem_sub : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= STEP_W'(FRAC_W);
        rem     <= {1'b0, num};
        quot    <= '0;
      end else if (running) begin
        rem   <= {rem_next[31:0], 1'b0};
        quot  <= {quot[FRAC_W-2:0], ge};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/keyframe_vector_sampler.sv -----
// Keyframe vector sampler: keyframe table with piecewise linear xyz sampling.
//
//   channel  dir  handshake            payload
//   req      in   valid / ready        opcode, key_time, key_x, key_y, key_z, sample_time
//   rsp      out  valid / ready        out_x, out_y, out_z, status
//
// One item in flight: req.ready is high only while the sequencer is idle.
// Clear, append and no-op items pass from idle straight to S_DONE and the output register.
// A sample walks the time memory one key at a time (registered read, then
// compare), then for a bracketing segment of nonzero length runs a serial
// divide for the fraction and three passes of subtract, multiply, add.
// Reset (rst, synchronous) empties the table; the memories are not cleared.
// A stalled rsp holds the result; the sequencer waits on it before going idle.
`default_nettype none

module keyframe_vector_sampler
  import kvs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  kvs_req_if.sink   req,
  kvs_rsp_if.source rsp
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_FETCH = 10'b0000000010,  // read address settling into the memory register
    S_SCAN  = 10'b0000000100,  // compare one key time
    S_SEGF  = 10'b0000001000,  // fetch earlier key of bracketing segment
    S_SEGA  = 10'b0000010000,  // latch earlier key, launch divide unless flat
    S_DIV   = 10'b0000100000,
    S_SUB   = 10'b0001000000,
    S_MUL   = 10'b0010000000,
    S_ADD   = 10'b0100000000,
    S_DONE  = 10'b1000000000   // hand the result to the output register
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [KEY_AW-1:0] addr;
  logic              first;
  logic [31:0]       samp_t;
  logic [31:0]       prev_t;
  logic [31:0]       num_r;
  logic [31:0]       den_r;
  logic              flat;
  logic [1:0]        comp;
  logic [31:0]       a_v   [3];
  logic [31:0]       b_v   [3];
  logic [31:0]       res_v [3];
  status_t           res_st;
  logic signed [32:0] dreg;
  logic signed [50:0] prod;

  logic              out_valid;
  logic [31:0]       out_x;
  logic [31:0]       out_y;
  logic [31:0]       out_z;
  status_t           out_st;

  kvs_wr_t           wr;
  logic [31:0]       rd_time;
  logic [31:0]       rd_x;
  logic [31:0]       rd_y;
  logic [31:0]       rd_z;

  logic              div_start;
  logic              div_done;
  logic [FRAC_W-1:0] frac;

  logic              accept;
  logic              full;
  logic              bracket;
  logic              last_key;
  op_t               op;

  assign op        = op_t'(req.opcode);
  assign accept    = req.valid && req.ready;
  assign full      = count == CNT_W'(MAX_KEYS);
  assign req.ready = state == S_IDLE;

  // Segment test against the previous key time; the last stored key ends the scan.
  assign bracket  = (prev_t <= samp_t) && (samp_t <= rd_time);
  assign last_key = (CNT_W'(addr) + CNT_W'(1)) == count;

  always_comb begin
    wr.en       = accept && (op == OP_APPEND) && !full;
    wr.addr     = count[KEY_AW-1:0];
    wr.key_time = req.key_time;
    wr.key_x    = req.key_x;
    wr.key_y    = req.key_y;
    wr.key_z    = req.key_z;
  end

  assign div_start = (state == S_SEGA) && !flat;

  kvs_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (addr),
    .rd_time (rd_time),
    .rd_x    (rd_x),
    .rd_y    (rd_y),
    .rd_z    (rd_z)
  );

  kvs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (frac)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      addr  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_v[0] <= '0;
            res_v[1] <= '0;
            res_v[2] <= '0;
            res_st   <= ST_DONE;
            state    <= S_DONE;
            case (op)
              OP_CLEAR: begin
                count <= '0;
              end
              OP_APPEND: begin
                if (full) begin
                  res_st <= ST_FULL;
                end else begin
                  count <= count + CNT_W'(1);
                end
              end
              OP_SAMPLE: begin
                samp_t <= req.sample_time;
                if (count == '0) begin
                  res_st <= ST_EMPTY;
                end else begin
                  res_st <= ST_SAMPLED;
                  addr   <= '0;
                  first  <= 1'b1;
                  state  <= S_FETCH;
                end
              end
              default: ;
            endcase
          end
        end
        S_FETCH: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          prev_t <= rd_time;
          if (first) begin
            // Single key, or query at or before the first key.
            if (count == CNT_W'(1) || samp_t <= rd_time) begin
              res_v[0] <= rd_x;
              res_v[1] <= rd_y;
              res_v[2] <= rd_z;
              state    <= S_DONE;
            end else begin
              first <= 1'b0;
              addr  <= KEY_AW'(1);
              state <= S_FETCH;
            end
          end else if (bracket) begin
            b_v[0] <= rd_x;
            b_v[1] <= rd_y;
            b_v[2] <= rd_z;
            num_r  <= samp_t - prev_t;
            den_r  <= rd_time - prev_t;
            flat   <= rd_time == prev_t;
            addr   <= addr - KEY_AW'(1);
            state  <= S_SEGF;
          end else if (last_key) begin
            // Past the end: hold the last value.
            res_v[0] <= rd_x;
            res_v[1] <= rd_y;
            res_v[2] <= rd_z;
            state    <= S_DONE;
          end else begin
            addr  <= addr + KEY_AW'(1);
            state <= S_FETCH;
          end
        end
        S_SEGF: begin
          state <= S_SEGA;
        end
        S_SEGA: begin
          a_v[0] <= rd_x;
          a_v[1] <= rd_y;
          a_v[2] <= rd_z;
          if (flat) begin
            // Equal key times: earlier key wins.
            res_v[0] <= rd_x;
            res_v[1] <= rd_y;
            res_v[2] <= rd_z;
            state    <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          comp <= 2'd0;
          if (div_done) begin
            state <= S_SUB;
          end
        end
        S_SUB: begin
          dreg  <= {b_v[comp][31], b_v[comp]} - {a_v[comp][31], a_v[comp]};
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= dreg * $signed({1'b0, frac});
          state <= S_ADD;
        end
        S_ADD: begin
          // a + floor(d * f / 2^16); only the low 32 bits survive.
          res_v[comp] <= a_v[comp] + prod[47:16];
          comp        <= comp + 2'd1;
          state       <= (comp == 2'd2) ? S_DONE : S_SUB;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
        out_x     <= res_v[0];
        out_y     <= res_v[1];
        out_z     <= res_v[2];
        out_st    <= res_st;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.out_x  = out_x;
  assign rsp.out_y  = out_y;
  assign rsp.out_z  = out_z;
  assign rsp.status = out_st;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_KEYS))
    else $error("key count beyond table depth");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside divide phase");

  a_add_sampled: assert property (@(posedge clk) disable iff (rst)
    state == S_ADD |-> res_st == ST_SAMPLED)
    else $error("interpolation running on a non-sample item");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> count == $past(count) + CNT_W'(1))
    else $error("append did not advance key count");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the keyframe vector sampler: directed, full-table, stall and random runs.
module testbench;
  import kvs_pkg::*;

  // Run limit for the watchdog: room for the slowest samples and for random
  // idle gaps on both sides of every item.
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int END_SETTLE   = 2 * MAX_KEYS + 60;
  localparam int HOLDOFF_LEN  = 400;
  localparam int ITEM_TARGET  = 1300;

  typedef struct {
    op_t         op;
    logic [31:0] key_time;
    logic [31:0] key_x;
    logic [31:0] key_y;
    logic [31:0] key_z;
    logic [31:0] sample_time;
  } kvs_item_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    status_t     status;
  } kvs_answer_t;

  logic clk;
  logic rst;

  kvs_req_if req ();
  kvs_rsp_if rsp ();

  keyframe_vector_sampler u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Bench copy of the keyframe table, updated as each item is accepted.
  logic [31:0] tab_time [MAX_KEYS];
  logic [31:0] tab_x    [MAX_KEYS];
  logic [31:0] tab_y    [MAX_KEYS];
  logic [31:0] tab_z    [MAX_KEYS];
  int unsigned tab_count = 0;

  // Answers owed by the block, oldest first.
  kvs_answer_t answers_due [$];

  int  fail_count  = 0;
  int  items_sent  = 0;
  int  cycle_count = 0;
  int  n_sampled   = 0;
  int  n_empty     = 0;
  int  n_full      = 0;
  int  n_done      = 0;

  bit  src_idle    = 1'b1;   // sender draws random gaps
  bit  snk_idle    = 1'b1;   // receiver draws random stalls
  int  holdoff_req = 0;      // long receiver stall, picked up by the sink process
  bit  rsp_taken   = 1'b0;   // result accepted at the coming edge

  // ---------------------------------------------------------------- clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t ns: timed out after %0d cycles, %0d answers outstanding",
               $time, cycle_count, answers_due.size());
      $display("status: fail");
      $finish;
    end
  end

  // ------------------------------------------------------------ predictor
  function automatic kvs_answer_t key_vector(int unsigned idx);
    kvs_answer_t ans;
    ans = '{tab_x[idx], tab_y[idx], tab_z[idx], ST_SAMPLED};
    return ans;
  endfunction

  // a + floor((b - a) * f / 65536), signed, f in 0..65536
  function automatic logic [31:0] lerp_component(logic [31:0] a, logic [31:0] b,
                                                 longint unsigned f);
    longint av;
    longint d;
    longint r;
    av = longint'(signed'(a));
    d  = longint'(signed'(b)) - av;
    r  = av + ((d * longint'(f)) >>> 16);
    return r[31:0];
  endfunction

  // Applies one item to the bench table and returns the answer it earns.
  function automatic kvs_answer_t table_answer(kvs_item_t it);
    kvs_answer_t     ans;
    int unsigned     i;
    int unsigned     hit;
    bit              found;
    longint unsigned t0;
    longint unsigned t1;
    longint unsigned frac;
    ans = '{32'd0, 32'd0, 32'd0, ST_DONE};
    case (it.op)
      OP_CLEAR: begin
        tab_count = 0;
      end
      OP_APPEND: begin
        if (tab_count >= MAX_KEYS) begin
          ans.status = ST_FULL;
        end else begin
          tab_time[tab_count] = it.key_time;
          tab_x[tab_count]    = it.key_x;
          tab_y[tab_count]    = it.key_y;
          tab_z[tab_count]    = it.key_z;
          tab_count++;
        end
      end
      OP_SAMPLE: begin
        if (tab_count == 0) begin
          ans.status = ST_EMPTY;
        end else if (tab_count == 1 || it.sample_time <= tab_time[0]) begin
          ans = key_vector(0);
        end else begin
          // first segment whose ends bracket the query, in table order
          found = 1'b0;
          hit   = 0;
          for (i = 0; i + 1 < tab_count && !found; i++) begin
            if (tab_time[i] <= it.sample_time && it.sample_time <= tab_time[i + 1]) begin
              found = 1'b1;
              hit   = i;
            end
          end
          if (!found) begin
            ans = key_vector(tab_count - 1);
          end else begin
            t0 = tab_time[hit];
            t1 = tab_time[hit + 1];
            if (t1 == t0) begin
              ans = key_vector(hit);   // zero-length segment: earlier key wins
            end else begin
              frac = ((longint'(it.sample_time) - t0) << 16) / (t1 - t0);
              ans.x = lerp_component(tab_x[hit], tab_x[hit + 1], frac);
              ans.y = lerp_component(tab_y[hit], tab_y[hit + 1], frac);
              ans.z = lerp_component(tab_z[hit], tab_z[hit + 1], frac);
              ans.status = ST_SAMPLED;
            end
          end
        end
      end
      default: ;   // no-op: table untouched, plain acknowledge
    endcase
    return ans;
  endfunction

  // ------------------------------------------------------------- checking
  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Outputs are sampled mid-cycle, where nothing is changing; a result
  // seen here with ready high is taken at the next rising edge.
  always @(negedge clk) begin : result_check
    kvs_answer_t want;
    rsp_taken = 1'b0;
    if (rst === 1'b0 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      rsp_taken = 1'b1;
      if (answers_due.size() == 0) begin
        $display("%0t ns: unexpected result x=%h y=%h z=%h st=%0d",
                 $time, rsp.out_x, rsp.out_y, rsp.out_z, rsp.status);
        fail_count++;
      end else begin
        want = answers_due.pop_front();
        field_check("out_x", want.x, rsp.out_x);
        field_check("out_y", want.y, rsp.out_y);
        field_check("out_z", want.z, rsp.out_z);
        field_check("status", {30'd0, want.status}, {30'd0, rsp.status});
        case (want.status)
          ST_SAMPLED: n_sampled++;
          ST_EMPTY:   n_empty++;
          ST_FULL:    n_full++;
          default:    n_done++;
        endcase
      end
    end
  end

  // --------------------------------------------------------- result sink
  // Random stall after each taken result while snk_idle is set; a long hold-off, when asked
  // for, is counted down here cycle by cycle.
  initial begin : result_sink
    int stall;
    stall = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req > 0) begin
        stall       = holdoff_req;
        holdoff_req = 0;
      end else if (rsp_taken) begin
        stall = snk_idle ? $urandom_range(0, 15) : 0;
      end
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        stall--;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------- sender
  // Called at a rising edge; returns just after the edge that took the item.
  // valid is only dropped when a gap follows, so it never toggles in one step.
  task automatic send_item(input kvs_item_t it);
    int          gap;
    kvs_answer_t owed;
    gap = src_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.opcode      <= it.op;
    req.key_time    <= it.key_time;
    req.key_x       <= it.key_x;
    req.key_y       <= it.key_y;
    req.key_z       <= it.key_z;
    req.sample_time <= it.sample_time;
    do @(negedge clk); while (req.ready !== 1'b1);
    @(posedge clk);
    owed        = table_answer(it);
    answers_due = {answers_due, owed};
    items_sent++;
  endtask

  function automatic kvs_item_t mk_item(op_t op, logic [31:0] kt, logic [31:0] kx,
                                        logic [31:0] ky, logic [31:0] kz, logic [31:0] st);
    kvs_item_t it;
    it = '{op, kt, kx, ky, kz, st};
    return it;
  endfunction

  // Unused fields carry random junk so that their bits move too.
  task automatic do_clear();
    send_item(mk_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic do_append(logic [31:0] t, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_item(mk_item(OP_APPEND, t, x, y, z, $urandom));
  endtask

  task automatic do_sample(logic [31:0] t);
    send_item(mk_item(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom, t));
  endtask

  // Sender stops and waits for every answer owed.
  task automatic pause_until_drained();
    req.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  // Appends n keys in nondecreasing time with random vectors. Step size
  // mode: tiny steps (lots of equal times), medium, or spread over the
  // whole 32-bit range.
  task automatic load_rising_table(int n);
    int              mode;
    logic [31:0]     t;
    logic [31:0]     smax;
    logic [31:0]     step;
    longint unsigned room;
    mode = $urandom_range(0, 3);
    t    = (mode == 0) ? $urandom_range(0, 255) : $urandom;
    room = 64'h0000_0000_FFFF_FFFF - longint'(t);
    smax = 32'(room / n);
    repeat (n) begin
      do_append(t, $urandom, $urandom, $urandom);
      case (mode)
        1:       step = $urandom_range(0, 3);
        2:       step = $urandom_range(0, 262144);
        default: step = $urandom_range(0, smax);
      endcase
      if (step > smax) step = smax;
      t = t + step;
    end
  endtask

  // Query mostly inside a stored segment, else at a key, before the first
  // key, past the last, or anywhere.
  task automatic sample_somewhere();
    int unsigned pick;
    int unsigned i;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] t;
    pick = $urandom_range(0, 19);
    if (tab_count == 0) begin
      t = $urandom;
    end else if (pick < 12 && tab_count > 1) begin
      i  = $urandom_range(0, tab_count - 2);
      lo = tab_time[i];
      hi = tab_time[i + 1];
      t  = (hi >= lo) ? lo + $urandom_range(0, hi - lo) : hi + $urandom_range(0, lo - hi);
    end else if (pick < 15) begin
      t = tab_time[$urandom_range(0, tab_count - 1)];
    end else if (pick < 17) begin
      t = $urandom_range(0, tab_time[0]);
    end else if (pick < 19) begin
      t = $urandom_range(tab_time[tab_count - 1], 32'hFFFF_FFFF);
    end else begin
      t = $urandom;
    end
    do_sample(t);
  endtask

  // ---------------------------------------------------------------- tests
  // Hand-picked items: extremes of the vector range, every opcode, the
  // empty table, a single key, equal key times, exact segment ends and
  // appends out of time order.
  task automatic test_directed();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    do_sample(32'hFFFF_FFFF);                                        // empty table
    send_item(mk_item(OP_NOP, '1, '1, '1, '1, '1));                  // no-op
    do_clear();
    do_append(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    do_sample(32'h0000_0000);                                        // before first key
    do_sample(32'hFFFF_FFFF);                                        // single key
    do_append(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF); // same time
    do_append(32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    do_append(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
    do_sample(32'h0001_0000);                                        // at first key
    do_sample(32'h0001_0001);                                        // smallest fraction
    do_sample(32'h0002_FFFF);                                        // fraction near one
    do_sample(32'h0003_0000);                                        // exact segment end
    do_sample(32'h8000_0000);                                        // wide span, big swing
    do_sample(32'hFFFF_FFFF);                                        // last key time
    do_append(32'h0000_8000, 32'h1234_5678, 32'hEDCB_A987, 32'h0000_0001); // out of order
    do_sample(32'hFFFF_FFFF);
    do_clear();
    do_append(32'h0002_0000, 32'h0000_0010, 32'hFFFF_FFF0, 32'h0100_0000);
    do_append(32'h0001_0000, 32'hFFFF_FF00, 32'h0000_0100, 32'hFF00_0000); // backwards
    do_sample(32'h0003_0000);                                        // nothing brackets
    do_sample(32'h0001_8000);
    send_item(mk_item(OP_NOP, '0, '0, '0, '0, '0));
    do_clear();
    do_sample(32'h0000_0000);                                        // empty after clear
    pause_until_drained();
  endtask

  // Fill every slot, then try to append past the end.
  task automatic test_table_full();
    src_idle = 1'b1;
    snk_idle = 1'b1;
    do_clear();
    load_rising_table(MAX_KEYS);
    repeat (3) do_append($urandom, $urandom, $urandom, $urandom);
    do_sample(tab_time[MAX_KEYS - 1]);
    do_sample(32'hFFFF_FFFF);
    repeat (8) sample_somewhere();
    pause_until_drained();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // items back to back, so the block holds its result and stalls its input.
  task automatic test_backpressure();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    do_clear();
    load_rising_table(4);
    holdoff_req = HOLDOFF_LEN;
    repeat (16) sample_somewhere();
    pause_until_drained();
  endtask

  // Mostly well-formed runs (clear, rising table, queries) with random
  // content; some noise, unordered tables and overfilled tables.
  task automatic test_random();
    int kind;
    while (items_sent < ITEM_TARGET) begin
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      kind     = $urandom_range(0, 29);
      if (kind < 22) begin
        do_clear();
        if ($urandom_range(0, 5) == 0) sample_somewhere();
        load_rising_table(($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_KEYS)
                                                       : $urandom_range(1, 8));
        repeat ($urandom_range(2, 12)) sample_somewhere();
      end else if (kind < 26) begin
        repeat ($urandom_range(4, 12))
          send_item(mk_item(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                            $urandom, $urandom));
      end else if (kind < 29) begin
        do_clear();
        repeat ($urandom_range(2, 10)) do_append($urandom, $urandom, $urandom, $urandom);
        repeat ($urandom_range(2, 8)) sample_somewhere();
      end else begin
        while (tab_count < MAX_KEYS) do_append($urandom, $urandom, $urandom, $urandom);
        repeat (2) do_append($urandom, $urandom, $urandom, $urandom);
        repeat (4) sample_somewhere();
      end
      if ($urandom_range(0, 7) == 0) pause_until_drained();
    end
  endtask

  // ----------------------------------------------------------------- main
  initial begin : run
    rst             <= 1'b1;
    req.valid       <= 1'b0;
    req.opcode      <= OP_CLEAR;
    req.key_time    <= '0;
    req.key_x       <= '0;
    req.key_y       <= '0;
    req.key_z       <= '0;
    req.sample_time <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_table_full();
    test_backpressure();
    test_random();

    pause_until_drained();
    repeat (END_SETTLE) @(posedge clk);

    $display("ran %0d items over %0d cycles: %0d samples, %0d on an empty table,",
             items_sent, cycle_count, n_sampled, n_empty);
    $display("%0d appends refused on a full table, %0d other acks, %0d mismatches",
             n_full, n_done, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
